### hdl/afr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types, codes and constants of the arrival feedback recorder.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int SEQ_SPACE_DEF   = 65536;
    localparam int MAX_SAMPLES_DEF = 32;

    localparam int SEQ_BITS  = 16;
    localparam int TIME_BITS = 48;
    localparam int RATE_BITS = 32;
    localparam int IVL_BITS  = 16;
    localparam int CFG_BITS  = 16;
    localparam int CFGI_BITS = 14;

    // Feedback packet size in bits times 1000: (20 + 8 + 10 + 170) * 8 * 1000
    localparam longint REPORT_BITS_K = 64'd1664000;
    localparam longint F20           = 20 * REPORT_BITS_K;
    localparam longint TWO_K         = 2 * REPORT_BITS_K;

    localparam int PROD_BITS = RATE_BITS + CFGI_BITS;
    // numerator holds 2 * REPORT_BITS_K times the widest interval register
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = 6;

    localparam int RESQ_DEPTH = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_BACK_WINDOW  = 3'd0;
    localparam logic [2:0] CFG_MAX_PRUNE    = 3'd1;
    localparam logic [2:0] CFG_MIN_INTERVAL = 3'd2;
    localparam logic [2:0] CFG_MAX_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_INIT_INTERVAL = 3'd4;

    localparam logic [CFG_BITS-1:0]  RST_BACK_WINDOW  = 16'd500;
    localparam logic [CFG_BITS-1:0]  RST_MAX_PRUNE    = 16'd50;
    localparam logic [CFGI_BITS-1:0] RST_MIN_INTERVAL = 14'd50;
    localparam logic [CFGI_BITS-1:0] RST_MAX_INTERVAL = 14'd250;
    localparam logic [CFGI_BITS-1:0] RST_INIT_INTERVAL = 14'd100;

    // Function codes
    localparam logic [1:0] FN_ARRIVAL = 2'd0;
    localparam logic [1:0] FN_RATE    = 2'd1;
    localparam logic [1:0] FN_TICK    = 2'd2;
    localparam logic [1:0] FN_UNUSED  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_INTERVAL = 3'd2;
    localparam logic [2:0] ST_NOT_DUE  = 3'd3;
    localparam logic [2:0] ST_REFUSED  = 3'd4;
    localparam logic [2:0] ST_SAMPLE   = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef enum logic [1:0] {
        K_ARRIVAL = 2'd0,
        K_RATE    = 2'd1,
        K_TICK    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [SEQ_BITS-1:0]   seq;
        logic [TIME_BITS-1:0]  now;
        logic [RATE_BITS-1:0]  bitrate;
    } t_cmd;

    typedef struct packed {
        logic [2:0]            status;
        logic [SEQ_BITS-1:0]   sample_seq;
        logic [TIME_BITS-1:0]  sample_time;
        logic [SEQ_BITS-1:0]   base_seq;
        logic [IVL_BITS-1:0]   interval_ms;
        logic                  last;
    } t_res;

    typedef struct packed {
        logic [CFG_BITS-1:0]   back_window;
        logic [CFG_BITS-1:0]   max_prune;
        logic [CFGI_BITS-1:0]  min_interval;
        logic [CFGI_BITS-1:0]  max_interval;
    } t_cfg;

endpackage
`default_nettype wire

### hdl/afr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_front
// Input side: takes requests, drops unused function codes, and queues the
// classified commands for the engine.
// ----------------------------------------------------------------------------
module afr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_hold,
    input  wire logic [1:0]                    i_func,
    input  wire logic [afr_pkg::SEQ_BITS-1:0]  i_seq_number,
    input  wire logic [afr_pkg::TIME_BITS-1:0] i_time_ms,
    input  wire logic [afr_pkg::RATE_BITS-1:0] i_bitrate_bps,
    output logic                               o_cmd_vld,
    output afr_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_cmd_pop
);
    import afr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, store, take;
    t_cmd       cmd_in;

    assign full      = (r_cnt == 2'd2) || i_hold;
    assign accept    = push && !full;
    assign store     = accept && (i_func != FN_UNUSED);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_slot[r_rp];
    assign take      = i_cmd_pop && o_cmd_vld;

    always_comb begin
        cmd_in.kind    = t_kind'(i_func);
        cmd_in.seq     = i_seq_number;
        cmd_in.now     = i_time_ms;
        cmd_in.bitrate = i_bitrate_bps;
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_slot[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (store) r_wp <= ~r_wp;
            if (take)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(store) - 2'(take);
        end
    end

endmodule
`default_nettype wire

### hdl/afr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [afr_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [afr_pkg::DIV_DEN_W-1:0] i_den,
    output logic                               o_done,
    output logic [afr_pkg::DIV_NUM_W-1:0]      o_quot
);
    import afr_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    assign shifted = {r_rem, r_num[DIV_NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            // quotient bits shift in where numerator bits leave
            r_num <= {r_num[DIV_NUM_W-2:0], fits};
            r_rem <= fits ? DIV_DEN_W'(shifted - {1'b0, r_den})
                          : DIV_DEN_W'(shifted);
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/afr_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_resq
// Result queue between the engine and the output ports.
// ----------------------------------------------------------------------------
module afr_resq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  afr_pkg::t_res      i_res,
    output logic               o_full,
    output logic               empty,
    input  wire logic          pop,
    output afr_pkg::t_res      o_res
);
    import afr_pkg::*;

    localparam int PW = $clog2(RESQ_DEPTH);

    t_res          r_mem [RESQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          wr, rd;

    assign o_full = (r_cnt == (PW+1)'(RESQ_DEPTH));
    assign empty  = (r_cnt == '0);
    assign wr     = i_push && !o_full;
    assign rd     = pop && !empty;
    assign o_res  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_res;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + PW'(1);
            if (rd) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

endmodule
`default_nettype wire

### hdl/afr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_back
// Engine: arrival store, pruning and report walks, interval computation.
// ----------------------------------------------------------------------------
module afr_back #(
    parameter int SEQ_SPACE   = afr_pkg::SEQ_SPACE_DEF,
    parameter int MAX_SAMPLES = afr_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  afr_pkg::t_cfg  i_cfg,
    input  wire logic      i_cmd_vld,
    input  afr_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    output logic           o_clearing,
    output logic           o_res_push,
    output afr_pkg::t_res  o_res,
    input  wire logic      i_res_full
);
    import afr_pkg::*;

    localparam int SW = $clog2(SEQ_SPACE);
    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam logic [SW:0] HALF_M1 = (SW+1)'(SEQ_SPACE / 2 - 1);

    typedef enum logic [14:0] {
        S_CLEAR   = 15'b000000000000001,
        S_IDLE    = 15'b000000000000010,
        S_ARR_CHK = 15'b000000000000100,
        S_PR_RD   = 15'b000000000001000,
        S_PR_EV   = 15'b000000000010000,
        S_ARR_RD  = 15'b000000000100000,
        S_ARR_WR  = 15'b000000001000000,
        S_RT_MUL  = 15'b000000010000000,
        S_RT_SEL  = 15'b000000100000000,
        S_RT_DIV  = 15'b000001000000000,
        S_RT_OUT  = 15'b000010000000000,
        S_TK_CHK  = 15'b000100000000000,
        S_TK_RD   = 15'b001000000000000,
        S_TK_EV   = 15'b010000000000000,
        S_TK_END  = 15'b100000000000000
    } t_state;

    // stores
    logic [TIME_BITS-1:0] mem_time [SEQ_SPACE];
    logic                 mem_vld  [SEQ_SPACE];

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [SW-1:0]         r_ws, n_ws, r_hs, n_hs;
    logic [SW:0]           r_cnt, n_cnt;
    logic [IVL_BITS-1:0]   r_ivl, n_ivl;
    logic [TIME_BITS-1:0]  r_lrt, n_lrt;
    logic                  r_once, n_once;
    logic [SW-1:0]         r_k, n_k;
    logic [CFG_BITS-1:0]   r_pruned, n_pruned;
    logic [NW-1:0]         r_n, n_n;
    logic [SW-1:0]         r_next, n_next, r_base, n_base;
    logic                  r_pend, n_pend;
    logic [SW-1:0]         r_pend_seq, n_pend_seq;
    logic [TIME_BITS-1:0]  r_pend_time, n_pend_time;
    logic [PROD_BITS-1:0]  r_pmn, r_pmx;
    logic [DIV_NUM_W-1:0]  r_nmn, r_nmx;
    logic [TIME_BITS-1:0]  r_rd_time;
    logic                  r_rd_vld;

    logic [SW-1:0]         seq, rd_addr, vld_wa;
    logic                  vld_we, vld_wd, time_we;
    logic [CFGI_BITS-1:0]  mn, mx;
    logic                  div_start, div_done;
    logic [DIV_NUM_W-1:0]  div_num, div_quot;
    logic [DIV_DEN_W-1:0]  div_den;
    logic                  stale, due;
    logic [TIME_BITS-1:0]  age;
    logic [1:0]            sel;

    assign seq        = r_cmd.seq[SW-1:0];
    assign mn         = (i_cfg.min_interval == '0) ? CFGI_BITS'(1) : i_cfg.min_interval;
    assign mx         = (i_cfg.max_interval == '0) ? CFGI_BITS'(1) : i_cfg.max_interval;
    assign o_clearing = (r_state == S_CLEAR);
    assign rd_addr    = (r_state == S_ARR_RD || r_state == S_ARR_WR) ? seq : r_k;
    assign stale      = ({1'b0, r_cmd.now}
                         >= ({1'b0, r_rd_time} + (TIME_BITS+1)'(i_cfg.back_window)));
    assign age        = r_cmd.now - r_lrt;
    assign due        = !r_once || ((r_cmd.now >= r_lrt)
                         && (age >= TIME_BITS'(r_ivl)));

    afr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // clamp selection: 0 middle, 1 upper rate bound, 2 lower rate bound
    always_comb begin
        sel = 2'd0;
        if (r_pmn > PROD_BITS'(F20)) sel = 2'd1;
        if (sel == 2'd0 && r_pmx < PROD_BITS'(F20)) sel = 2'd2;
        if (sel == 2'd1 && mn > mx) sel = 2'd2;
        case (sel)
            2'd1: begin
                div_num = r_nmn;
                div_den = DIV_DEN_W'(mn) + DIV_DEN_W'(TWO_K);
            end
            2'd2: begin
                div_num = r_nmx;
                div_den = DIV_DEN_W'(mx) + DIV_DEN_W'(TWO_K);
            end
            default: begin
                div_num = DIV_NUM_W'(F20);
                div_den = DIV_DEN_W'(r_cmd.bitrate) + DIV_DEN_W'(10);
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ws        = r_ws;
        n_hs        = r_hs;
        n_cnt       = r_cnt;
        n_ivl       = r_ivl;
        n_lrt       = r_lrt;
        n_once      = r_once;
        n_k         = r_k;
        n_pruned    = r_pruned;
        n_n         = r_n;
        n_next      = r_next;
        n_base      = r_base;
        n_pend      = r_pend;
        n_pend_seq  = r_pend_seq;
        n_pend_time = r_pend_time;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;
        vld_we      = 1'b0;
        vld_wa      = r_k;
        vld_wd      = 1'b0;
        time_we     = 1'b0;
        div_start   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                vld_we = 1'b1;
                n_k    = r_k + SW'(1);
                if (r_k == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.kind)
                        K_ARRIVAL: n_state = S_ARR_CHK;
                        K_RATE:    n_state = S_RT_MUL;
                        K_TICK:    n_state = S_TK_CHK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ARR_CHK: begin
                if ({1'b0, seq} > ({1'b0, r_ws} + HALF_M1)) begin
                    o_res.status = ST_REJECTED;
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_hs <= r_ws && seq != '0 && i_cfg.max_prune != '0) begin
                    n_k      = '0;
                    n_pruned = '0;
                    n_state  = S_PR_RD;
                end else begin
                    n_state = S_ARR_RD;
                end
            end
            S_PR_RD: n_state = S_PR_EV;
            S_PR_EV: begin
                if (r_rd_vld && stale) begin
                    vld_we   = 1'b1;
                    n_cnt    = r_cnt - (SW+1)'(1);
                    n_pruned = r_pruned + CFG_BITS'(1);
                end
                n_k = r_k + SW'(1);
                if (n_k == seq || n_pruned == i_cfg.max_prune) n_state = S_ARR_RD;
                else n_state = S_PR_RD;
            end
            S_ARR_RD: n_state = S_ARR_WR;
            S_ARR_WR: begin
                o_res.status = ST_STORED;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    time_we    = 1'b1;
                    vld_we     = 1'b1;
                    vld_wa     = seq;
                    vld_wd     = 1'b1;
                    if (!r_rd_vld) n_cnt = r_cnt + (SW+1)'(1);
                    if (r_ws == '0 || seq < r_ws) n_ws = seq;
                    if (seq > r_hs) n_hs = seq;
                    n_state = S_IDLE;
                end
            end
            S_RT_MUL: n_state = S_RT_SEL;
            S_RT_SEL: begin
                div_start = 1'b1;
                n_state   = S_RT_DIV;
            end
            S_RT_DIV: begin
                if (div_done) begin
                    n_ivl   = (div_quot[DIV_NUM_W-1:IVL_BITS] != '0) ? '1
                                                                   : div_quot[IVL_BITS-1:0];
                    n_state = S_RT_OUT;
                end
            end
            S_RT_OUT: begin
                o_res.status      = ST_INTERVAL;
                o_res.interval_ms = r_ivl;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TK_CHK: begin
                if (!due) begin
                    o_res.status = ST_NOT_DUE;
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_hs <= r_ws && r_cnt > (SW+1)'(2)) begin
                    o_res.status = ST_REFUSED;
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_base  = r_ws;
                    n_k     = '0;
                    n_n     = '0;
                    n_next  = '0;
                    n_pend  = 1'b0;
                    n_state = S_TK_RD;
                end
            end
            S_TK_RD: n_state = S_TK_EV;
            S_TK_EV: begin
                o_res.status      = ST_SAMPLE;
                o_res.sample_seq  = SEQ_BITS'(r_pend_seq);
                o_res.sample_time = r_pend_time;
                o_res.base_seq    = SEQ_BITS'(r_base);
                o_res.last        = 1'b0;
                // hold while an earlier sample cannot leave yet
                if (!(r_rd_vld && r_k >= r_base && r_pend && i_res_full)) begin
                    if (r_rd_vld) begin
                        n_next = r_k + SW'(1);
                        if (r_k >= r_base) begin
                            o_res_push  = r_pend;
                            n_pend      = 1'b1;
                            n_pend_seq  = r_k;
                            n_pend_time = r_rd_time;
                            n_n         = r_n + NW'(1);
                        end
                    end
                    n_k = r_k + SW'(1);
                    if (n_n == NW'(MAX_SAMPLES) || r_k == '1) n_state = S_TK_END;
                    else n_state = S_TK_RD;
                end
            end
            S_TK_END: begin
                o_res.base_seq = SEQ_BITS'(r_base);
                if (r_pend) begin
                    o_res.status      = ST_SAMPLE;
                    o_res.sample_seq  = SEQ_BITS'(r_pend_seq);
                    o_res.sample_time = r_pend_time;
                end else begin
                    o_res.status = ST_EMPTY;
                end
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_n > NW'(2)) n_ws = r_next;
                    n_lrt   = r_cmd.now;
                    n_once  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_time <= mem_time[rd_addr];
        r_rd_vld  <= mem_vld[rd_addr];
        if (time_we) mem_time[seq] <= r_cmd.now;
        if (vld_we)  mem_vld[vld_wa] <= vld_wd;
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_pruned    <= n_pruned;
        r_n         <= n_n;
        r_next      <= n_next;
        r_base      <= n_base;
        r_pend_seq  <= n_pend_seq;
        r_pend_time <= n_pend_time;
        r_pmn       <= PROD_BITS'(r_cmd.bitrate) * PROD_BITS'(mn);
        r_pmx       <= PROD_BITS'(r_cmd.bitrate) * PROD_BITS'(mx);
        r_nmn       <= DIV_NUM_W'(TWO_K) * DIV_NUM_W'(mn);
        r_nmx       <= DIV_NUM_W'(TWO_K) * DIV_NUM_W'(mx);
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_ws    <= '0;
            r_hs    <= '0;
            r_cnt   <= '0;
            r_ivl   <= IVL_BITS'(RST_INIT_INTERVAL);
            r_lrt   <= '0;
            r_once  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ws    <= n_ws;
            r_hs    <= n_hs;
            r_cnt   <= n_cnt;
            r_ivl   <= n_ivl;
            r_lrt   <= n_lrt;
            r_once  <= n_once;
            r_pend  <= n_pend;
        end
    end

endmodule
`default_nettype wire

### hdl/arrival_feedback_recorder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arrival_feedback_recorder_unit
// Receive side of congestion feedback: records arrival times per sequence
// number, prunes stale entries, sets the report interval and walks reports.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// input     in         push / full         i_func, i_seq_number, i_time_ms,
//                                          i_bitrate_bps
// result    out        pop / empty         o_status, o_sample_seq, o_sample_time,
//                                          o_base_seq, o_interval_ms, o_last
// config    in         i_cfg_we            i_cfg_idx, i_cfg_wdata
//
// After reset the valid store is swept one entry a cycle with full held high.
// An arrival is checked, optionally prunes by reading and judging entries in
// turn, then is read and written; a bitrate item runs the divider, one bit a
// cycle; a due report reads and judges entries one at a time, as the store
// has a single read port. A full result queue stalls the engine.
// ----------------------------------------------------------------------------
module arrival_feedback_recorder_unit #(
    parameter int SEQ_SPACE   = afr_pkg::SEQ_SPACE_DEF,
    parameter int MAX_SAMPLES = afr_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    i_func,
    input  wire logic [afr_pkg::SEQ_BITS-1:0]  i_seq_number,
    input  wire logic [afr_pkg::TIME_BITS-1:0] i_time_ms,
    input  wire logic [afr_pkg::RATE_BITS-1:0] i_bitrate_bps,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [2:0]                         o_status,
    output logic [afr_pkg::SEQ_BITS-1:0]       o_sample_seq,
    output logic [afr_pkg::TIME_BITS-1:0]      o_sample_time,
    output logic [afr_pkg::SEQ_BITS-1:0]       o_base_seq,
    output logic [afr_pkg::IVL_BITS-1:0]       o_interval_ms,
    output logic                               o_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_idx,
    input  wire logic [afr_pkg::CFG_BITS-1:0]  i_cfg_wdata
);
    import afr_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_res res_in, res_out;
    logic cmd_vld, cmd_pop, clearing, res_push, res_full;

    // The initial interval only acts through its reset value, so a write to
    // it is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.back_window  <= RST_BACK_WINDOW;
            r_cfg.max_prune    <= RST_MAX_PRUNE;
            r_cfg.min_interval <= RST_MIN_INTERVAL;
            r_cfg.max_interval <= RST_MAX_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BACK_WINDOW:  r_cfg.back_window  <= i_cfg_wdata;
                CFG_MAX_PRUNE:    r_cfg.max_prune    <= i_cfg_wdata;
                CFG_MIN_INTERVAL: r_cfg.min_interval <= i_cfg_wdata[CFGI_BITS-1:0];
                CFG_MAX_INTERVAL: r_cfg.max_interval <= i_cfg_wdata[CFGI_BITS-1:0];
                default: ;
            endcase
        end
    end

    afr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_hold        (clearing),
        .i_func        (i_func),
        .i_seq_number  (i_seq_number),
        .i_time_ms     (i_time_ms),
        .i_bitrate_bps (i_bitrate_bps),
        .o_cmd_vld     (cmd_vld),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    afr_back #(
        .SEQ_SPACE   (SEQ_SPACE),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_clearing (clearing),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    afr_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_status      = res_out.status;
    assign o_sample_seq  = res_out.sample_seq;
    assign o_sample_time = res_out.sample_time;
    assign o_base_seq    = res_out.base_seq;
    assign o_interval_ms = res_out.interval_ms;
    assign o_last        = res_out.last;

endmodule
`default_nettype wire
